>>> hdl/pitt_pkg.sv
`timescale 1ns / 1ps

package pitt_pkg;

   // Table geometry.
   localparam int TIMER_SLOTS = 16;
   localparam int ID_BITS     = 16;
   localparam int SLOT_BITS   = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

   // Fixed field widths of the request and response words.
   localparam int OP_W    = 2;
   localparam int THREAD_W = 16;
   localparam int TIME_W  = 64;
   localparam int KIND_W  = 2;

   // Thread ids are compared and stored with only ID_BITS bits kept.
   localparam logic [THREAD_W-1:0] ID_MASK = (ID_BITS >= THREAD_W) ? {THREAD_W{1'b1}} :
      THREAD_W'((64'd1 << ID_BITS) - 64'd1);

   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(TIMER_SLOTS - 1);

   typedef enum logic [OP_W-1:0] {
      OP_SET   = 2'd0,
      OP_READ  = 2'd1,
      OP_CHECK = 2'd2
   } opcode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACK    = 2'd0,
      KIND_READ   = 2'd1,
      KIND_EXPIRY = 2'd2,
      KIND_DONE   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REPLY,
      ST_CHECK,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture the request word and restart the slot scan
      logic step;    // visit the current slot and advance the scan index
      logic reply;   // commit a set and emit its acknowledge or the read data
      logic expire;  // emit an expiry for the current slot and re-arm or free it
      logic finish;  // emit the check done word
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;  // scan index is on the final slot
      logic hit;        // current slot is valid and its deadline has passed
      logic out_free;   // output register can take a word this cycle
   } status_type;

endpackage

>>> hdl/pitt_ctrl.sv
`timescale 1ns / 1ps

module pitt_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [pitt_pkg::OP_W-1:0]      req_opcode,
   output logic                           req_ready,
   input  pitt_pkg::status_type           sts,
   output pitt_pkg::cmd_type              cmd
);

   pitt_pkg::state_type state_ff;
   pitt_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pitt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pitt_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_opcode)
                  pitt_pkg::OP_SET:   state_in = pitt_pkg::ST_SCAN;
                  pitt_pkg::OP_READ:  state_in = pitt_pkg::ST_SCAN;
                  pitt_pkg::OP_CHECK: state_in = pitt_pkg::ST_CHECK;
                  default:            state_in = pitt_pkg::ST_IDLE;
               endcase
            end
         end
         pitt_pkg::ST_SCAN: begin
            if (sts.scan_last) state_in = pitt_pkg::ST_REPLY;
         end
         pitt_pkg::ST_REPLY: begin
            if (sts.out_free) state_in = pitt_pkg::ST_IDLE;
         end
         pitt_pkg::ST_CHECK: begin
            if (sts.scan_last && (!sts.hit || sts.out_free)) state_in = pitt_pkg::ST_DONE;
         end
         pitt_pkg::ST_DONE: begin
            if (sts.out_free) state_in = pitt_pkg::ST_IDLE;
         end
         default: begin
            state_in = pitt_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         pitt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         pitt_pkg::ST_SCAN: begin
            cmd.step = 1'b1;
         end
         pitt_pkg::ST_REPLY: begin
            cmd.reply = sts.out_free;
         end
         pitt_pkg::ST_CHECK: begin
            // An expired slot holds the scan until its word can be emitted.
            if (sts.hit) begin
               cmd.expire = sts.out_free;
               cmd.step   = sts.out_free;
            end else begin
               cmd.step = 1'b1;
            end
         end
         pitt_pkg::ST_DONE: begin
            cmd.finish = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

>>> hdl/pitt_datapath.sv
`timescale 1ns / 1ps

module pitt_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [pitt_pkg::OP_W-1:0]         req_opcode,
   input  logic [pitt_pkg::THREAD_W-1:0]     req_thread_id,
   input  logic [pitt_pkg::TIME_W-1:0]       req_now_cycles,
   input  logic [pitt_pkg::TIME_W-1:0]       req_value_cycles,
   input  logic [pitt_pkg::TIME_W-1:0]       req_period_cycles,
   input  pitt_pkg::cmd_type                 cmd,
   output pitt_pkg::status_type              sts,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pitt_pkg::KIND_W-1:0]       rsp_kind,
   output logic [pitt_pkg::THREAD_W-1:0]     rsp_owner_id,
   output logic [pitt_pkg::TIME_W-1:0]       rsp_remaining_cycles,
   output logic [pitt_pkg::TIME_W-1:0]       rsp_reload_cycles,
   output logic                              rsp_status,
   output logic                              rsp_last
);

   localparam int SB = pitt_pkg::SLOT_BITS;
   localparam int TW = pitt_pkg::TIME_W;
   localparam int IW = pitt_pkg::THREAD_W;

   // Captured request word.
   logic [pitt_pkg::OP_W-1:0] op_ff, op_in;
   logic [IW-1:0]             id_ff, id_in;
   logic [TW-1:0]             now_ff, now_in;
   logic [TW-1:0]             value_ff, value_in;
   logic [TW-1:0]             period_ff, period_in;

   // Scan state and search results.
   logic [SB-1:0] idx_ff, idx_in;
   logic          match_ff, match_in;
   logic [SB-1:0] match_idx_ff, match_idx_in;
   logic          free_ff, free_in;
   logic [SB-1:0] free_idx_ff, free_idx_in;
   logic [TW-1:0] rd_rem_ff, rd_rem_in;
   logic [TW-1:0] rd_rel_ff, rd_rel_in;

   // Slot table.
   logic          valid_ff [pitt_pkg::TIMER_SLOTS];
   logic [IW-1:0] owner_ff [pitt_pkg::TIMER_SLOTS];
   logic [TW-1:0] deadline_ff [pitt_pkg::TIMER_SLOTS];
   logic [TW-1:0] reload_ff [pitt_pkg::TIMER_SLOTS];

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   pitt_pkg::kind_type rsp_kind_ff, rsp_kind_in;
   logic [IW-1:0]      rsp_owner_ff, rsp_owner_in;
   logic [TW-1:0]      rsp_rem_ff, rsp_rem_in;
   logic [TW-1:0]      rsp_rel_ff, rsp_rel_in;
   logic               rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;

   logic          cur_valid;
   logic [IW-1:0] cur_owner;
   logic [TW-1:0] cur_deadline;
   logic [TW-1:0] cur_period;
   logic          cur_future;
   logic          is_set;
   logic          full;
   logic [TW-1:0] addend;
   logic [TW-1:0] new_deadline;

   logic          wr_en;
   logic          wr_owner_en;
   logic [SB-1:0] wr_idx;
   logic          valid_set;
   logic          valid_clr;
   logic          emit;

   assign cur_valid    = valid_ff[idx_ff];
   assign cur_owner    = owner_ff[idx_ff];
   assign cur_deadline = deadline_ff[idx_ff];
   assign cur_period   = reload_ff[idx_ff];
   assign cur_future   = cur_deadline > now_ff;

   assign is_set = (op_ff == pitt_pkg::OP_SET);
   assign full   = !match_ff && (value_ff != '0) && !free_ff;

   // One adder serves the set deadline and the periodic re-arm.
   assign addend       = cmd.expire ? cur_period : value_ff;
   assign new_deadline = now_ff + addend;

   assign emit = cmd.reply || cmd.expire || cmd.finish;

   assign sts.scan_last = (idx_ff == pitt_pkg::LAST_SLOT);
   assign sts.hit       = cur_valid && !cur_future;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      op_in        = op_ff;
      id_in        = id_ff;
      now_in       = now_ff;
      value_in     = value_ff;
      period_in    = period_ff;
      idx_in       = idx_ff;
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      rd_rem_in    = rd_rem_ff;
      rd_rel_in    = rd_rel_ff;
      if (cmd.load) begin
         op_in     = req_opcode;
         id_in     = req_thread_id & pitt_pkg::ID_MASK;
         now_in    = req_now_cycles;
         value_in  = req_value_cycles;
         period_in = req_period_cycles;
         idx_in    = '0;
         match_in  = 1'b0;
         free_in   = 1'b0;
         rd_rem_in = '0;
         rd_rel_in = '0;
      end else if (cmd.step) begin
         if (!sts.scan_last) idx_in = idx_ff + SB'(1);
         if (cur_valid && (cur_owner == id_ff) && !match_ff) begin
            match_in     = 1'b1;
            match_idx_in = idx_ff;
            rd_rem_in    = cur_future ? (cur_deadline - now_ff) : '0;
            rd_rel_in    = cur_period;
         end
         if (!cur_valid && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         match_ff <= 1'b0;
         free_ff  <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         match_ff <= match_in;
         free_ff  <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      id_ff        <= id_in;
      now_ff       <= now_in;
      value_ff     <= value_in;
      period_ff    <= period_in;
      match_idx_ff <= match_idx_in;
      free_idx_ff  <= free_idx_in;
      rd_rem_ff    <= rd_rem_in;
      rd_rel_ff    <= rd_rel_in;
   end

   // Table updates from a committed set or from an expiry.
   always_comb begin
      wr_en       = 1'b0;
      wr_owner_en = 1'b0;
      wr_idx      = idx_ff;
      valid_set   = 1'b0;
      valid_clr   = 1'b0;
      if (cmd.reply && is_set) begin
         if (match_ff) begin
            wr_idx = match_idx_ff;
            if (value_ff == '0) begin
               valid_clr = 1'b1;
            end else begin
               wr_en = 1'b1;
            end
         end else if ((value_ff != '0) && free_ff) begin
            wr_idx      = free_idx_ff;
            wr_en       = 1'b1;
            wr_owner_en = 1'b1;
            valid_set   = 1'b1;
         end
      end else if (cmd.expire) begin
         if (cur_period != '0) begin
            wr_en = 1'b1;
         end else begin
            valid_clr = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pitt_pkg::TIMER_SLOTS; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (valid_set) begin
         valid_ff[wr_idx] <= 1'b1;
      end else if (valid_clr) begin
         valid_ff[wr_idx] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         deadline_ff[wr_idx] <= new_deadline;
         reload_ff[wr_idx]   <= cmd.expire ? cur_period : period_ff;
      end
      if (wr_owner_en) begin
         owner_ff[wr_idx] <= id_ff;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_owner_in  = rsp_owner_ff;
      rsp_rem_in    = rsp_rem_ff;
      rsp_rel_in    = rsp_rel_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) rsp_valid_in = 1'b1;
      if (cmd.reply) begin
         rsp_kind_in   = is_set ? pitt_pkg::KIND_ACK : pitt_pkg::KIND_READ;
         rsp_owner_in  = id_ff;
         rsp_rem_in    = is_set ? '0 : rd_rem_ff;
         rsp_rel_in    = is_set ? '0 : rd_rel_ff;
         rsp_status_in = is_set && full;
         rsp_last_in   = 1'b1;
      end else if (cmd.expire) begin
         rsp_kind_in   = pitt_pkg::KIND_EXPIRY;
         rsp_owner_in  = cur_owner;
         rsp_rem_in    = '0;
         rsp_rel_in    = cur_period;
         rsp_status_in = 1'b0;
         rsp_last_in   = 1'b0;
      end else if (cmd.finish) begin
         rsp_kind_in   = pitt_pkg::KIND_DONE;
         rsp_owner_in  = '0;
         rsp_rem_in    = '0;
         rsp_rel_in    = '0;
         rsp_status_in = 1'b0;
         rsp_last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff   <= rsp_kind_in;
      rsp_owner_ff  <= rsp_owner_in;
      rsp_rem_ff    <= rsp_rem_in;
      rsp_rel_ff    <= rsp_rel_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_kind             = rsp_kind_ff;
   assign rsp_owner_id         = rsp_owner_ff;
   assign rsp_remaining_cycles = rsp_rem_ff;
   assign rsp_reload_cycles    = rsp_rel_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_last             = rsp_last_ff;

endmodule

>>> hdl/per_thread_interval_timer_table.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Word
// req_*     in         req_valid/req_ready  opcode, thread_id, now, value, period
// rsp_*     out        rsp_valid/rsp_ready  kind, owner_id, remaining, reload, status, last
//
// One request word is taken at a time. The datapath visits one slot per cycle, save while a
// check holds the scan on an expired slot, so a set, read or check scans every slot between
// acceptance and the next ready. A word that cannot enter the output register, because the
// previous word still waits on rsp_ready, holds the block until the register is free.
// The output register lets a request be taken while the last response word is still held.
// Reset is synchronous and clears every slot's valid bit at once; there is no clearing pass.

module per_thread_interval_timer_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [pitt_pkg::OP_W-1:0]         req_opcode,
   input  logic [pitt_pkg::THREAD_W-1:0]     req_thread_id,
   input  logic [pitt_pkg::TIME_W-1:0]       req_now_cycles,
   input  logic [pitt_pkg::TIME_W-1:0]       req_value_cycles,
   input  logic [pitt_pkg::TIME_W-1:0]       req_period_cycles,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [pitt_pkg::KIND_W-1:0]       rsp_kind,
   output logic [pitt_pkg::THREAD_W-1:0]     rsp_owner_id,
   output logic [pitt_pkg::TIME_W-1:0]       rsp_remaining_cycles,
   output logic [pitt_pkg::TIME_W-1:0]       rsp_reload_cycles,
   output logic                              rsp_status,
   output logic                              rsp_last
);

   pitt_pkg::cmd_type    cmd;
   pitt_pkg::status_type sts;

   pitt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_ready  (req_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pitt_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_opcode           (req_opcode),
      .req_thread_id        (req_thread_id),
      .req_now_cycles       (req_now_cycles),
      .req_value_cycles     (req_value_cycles),
      .req_period_cycles    (req_period_cycles),
      .cmd                  (cmd),
      .sts                  (sts),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_kind             (rsp_kind),
      .rsp_owner_id         (rsp_owner_id),
      .rsp_remaining_cycles (rsp_remaining_cycles),
      .rsp_reload_cycles    (rsp_reload_cycles),
      .rsp_status           (rsp_status),
      .rsp_last             (rsp_last)
   );

   // A word is only produced when the output register can take it.
   a_emit_has_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.reply || cmd.expire || cmd.finish) |-> sts.out_free)
      else $error("response word produced while the output register is held");

   // A set or read always spends the slot scan before the next request.
   a_scan_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready &&
       (req_opcode == pitt_pkg::OP_SET || req_opcode == pitt_pkg::OP_READ))
      |=> !req_ready)
      else $error("request taken during a slot scan");

   // Table full is only ever reported on a set acknowledge.
   a_status_on_ack: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_kind == pitt_pkg::KIND_ACK))
      else $error("status set on a word that is not a set acknowledge");

   // An expiry word is never the final word of a check.
   a_expiry_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == pitt_pkg::KIND_EXPIRY) |-> !rsp_last)
      else $error("expiry word marked as last");

endmodule

>>> tb/sv/per_thread_interval_timer_table_tb.sv
`timescale 1ns / 1ps

module per_thread_interval_timer_table_tb;

   // The one opcode value that carries no meaning; the block must drop it silently.
   localparam logic [pitt_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [pitt_pkg::OP_W-1:0]     op;
      logic [pitt_pkg::THREAD_W-1:0] thread_id;
      logic [pitt_pkg::TIME_W-1:0]   now;
      logic [pitt_pkg::TIME_W-1:0]   value;
      logic [pitt_pkg::TIME_W-1:0]   period;
      bit                            hold;    // wait for every outstanding word before sending
   } timer_req_type;

   typedef struct {
      pitt_pkg::kind_type            kind;
      logic [pitt_pkg::THREAD_W-1:0] owner;
      logic [pitt_pkg::TIME_W-1:0]   remaining;
      logic [pitt_pkg::TIME_W-1:0]   reload;
      logic                          status;
      logic                          last;
   } timer_word_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [pitt_pkg::OP_W-1:0]     req_opcode = '0;
   logic [pitt_pkg::THREAD_W-1:0] req_thread_id = '0;
   logic [pitt_pkg::TIME_W-1:0]   req_now_cycles = '0;
   logic [pitt_pkg::TIME_W-1:0]   req_value_cycles = '0;
   logic [pitt_pkg::TIME_W-1:0]   req_period_cycles = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [pitt_pkg::KIND_W-1:0]   rsp_kind;
   logic [pitt_pkg::THREAD_W-1:0] rsp_owner_id;
   logic [pitt_pkg::TIME_W-1:0]   rsp_remaining_cycles;
   logic [pitt_pkg::TIME_W-1:0]   rsp_reload_cycles;
   logic                          rsp_status;
   logic                          rsp_last;

   per_thread_interval_timer_table uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_opcode           (req_opcode),
      .req_thread_id        (req_thread_id),
      .req_now_cycles       (req_now_cycles),
      .req_value_cycles     (req_value_cycles),
      .req_period_cycles    (req_period_cycles),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_kind             (rsp_kind),
      .rsp_owner_id         (rsp_owner_id),
      .rsp_remaining_cycles (rsp_remaining_cycles),
      .rsp_reload_cycles    (rsp_reload_cycles),
      .rsp_status           (rsp_status),
      .rsp_last             (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the timer table.
   logic                          tv_valid    [pitt_pkg::TIMER_SLOTS];
   logic [pitt_pkg::THREAD_W-1:0] tv_owner    [pitt_pkg::TIMER_SLOTS];
   logic [pitt_pkg::TIME_W-1:0]   tv_deadline [pitt_pkg::TIMER_SLOTS];
   logic [pitt_pkg::TIME_W-1:0]   tv_period   [pitt_pkg::TIMER_SLOTS];

   timer_req_type  pend_q[$];
   timer_word_type exp_q[$];
   timer_req_type  cur_req;
   logic [pitt_pkg::THREAD_W-1:0] id_pool[24];

   int n_errors = 0;
   int n_words = 0;
   int n_expiry_words = 0;
   int n_sets = 0;
   int n_full = 0;
   int n_reads = 0;
   int n_checks = 0;
   int send_gap = 0;
   int recv_gap = 0;
   bit send_steady = 1'b0;
   bit recv_steady = 1'b0;

   initial begin
      for (int i = 0; i < pitt_pkg::TIMER_SLOTS; i++) begin
         tv_valid[i] = 1'b0;
         tv_owner[i] = '0;
         tv_deadline[i] = '0;
         tv_period[i] = '0;
      end
   end

   task automatic report_mismatch(input string msg);
      n_errors++;
      $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   function automatic logic [pitt_pkg::TIME_W-1:0] rand_time();
      return {$urandom, $urandom};
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void queue_req(input logic [pitt_pkg::OP_W-1:0] op,
                                     input logic [pitt_pkg::THREAD_W-1:0] id,
                                     input logic [pitt_pkg::TIME_W-1:0] now,
                                     input logic [pitt_pkg::TIME_W-1:0] value,
                                     input logic [pitt_pkg::TIME_W-1:0] period,
                                     input bit hold = 1'b0);
      timer_req_type it;
      it.op = op;
      it.thread_id = id;
      it.now = now;
      it.value = value;
      it.period = period;
      it.hold = hold;
      pend_q.push_back(it);
   endfunction

   function automatic void push_word(input pitt_pkg::kind_type kind,
                                     input logic [pitt_pkg::THREAD_W-1:0] owner,
                                     input logic [pitt_pkg::TIME_W-1:0] remaining,
                                     input logic [pitt_pkg::TIME_W-1:0] reload,
                                     input logic status, input logic last);
      timer_word_type w;
      w.kind = kind;
      w.owner = owner;
      w.remaining = remaining;
      w.reload = reload;
      w.status = status;
      w.last = last;
      exp_q.push_back(w);
   endfunction

   function automatic int find_owner(input logic [pitt_pkg::THREAD_W-1:0] id);
      for (int i = 0; i < pitt_pkg::TIMER_SLOTS; i++)
         if (tv_valid[i] && tv_owner[i] == id)
            return i;
      return -1;
   endfunction

   // Updates the shadow table for one accepted request and queues the words it must produce.
   function automatic void timer_table_apply(input timer_req_type it);
      logic [pitt_pkg::THREAD_W-1:0] id;
      logic [pitt_pkg::TIME_W-1:0]   rem;
      logic [pitt_pkg::TIME_W-1:0]   rel;
      logic                          full;
      int                            s;
      int                            f;
      id = it.thread_id & pitt_pkg::ID_MASK;
      case (it.op)
         pitt_pkg::OP_SET: begin
            n_sets++;
            full = 1'b0;
            s = find_owner(id);
            if (s >= 0) begin
               if (it.value == '0) begin
                  tv_valid[s] = 1'b0;
               end else begin
                  tv_deadline[s] = it.now + it.value;
                  tv_period[s] = it.period;
               end
            end else if (it.value != '0) begin
               f = -1;
               for (int i = pitt_pkg::TIMER_SLOTS - 1; i >= 0; i--)
                  if (!tv_valid[i])
                     f = i;
               if (f >= 0) begin
                  tv_valid[f] = 1'b1;
                  tv_owner[f] = id;
                  tv_deadline[f] = it.now + it.value;
                  tv_period[f] = it.period;
               end else begin
                  full = 1'b1;
                  n_full++;
               end
            end
            push_word(pitt_pkg::KIND_ACK, id, '0, '0, full, 1'b1);
         end
         pitt_pkg::OP_READ: begin
            n_reads++;
            rem = '0;
            rel = '0;
            s = find_owner(id);
            if (s >= 0) begin
               rem = (tv_deadline[s] > it.now) ? tv_deadline[s] - it.now : '0;
               rel = tv_period[s];
            end
            push_word(pitt_pkg::KIND_READ, id, rem, rel, 1'b0, 1'b1);
         end
         pitt_pkg::OP_CHECK: begin
            n_checks++;
            for (int i = 0; i < pitt_pkg::TIMER_SLOTS; i++) begin
               if (tv_valid[i] && tv_deadline[i] <= it.now) begin
                  push_word(pitt_pkg::KIND_EXPIRY, tv_owner[i], '0, tv_period[i], 1'b0, 1'b0);
                  if (tv_period[i] != '0)
                     tv_deadline[i] = it.now + tv_period[i];
                  else
                     tv_valid[i] = 1'b0;
               end
            end
            push_word(pitt_pkg::KIND_DONE, '0, '0, '0, 1'b0, 1'b1);
         end
         default: begin
         end
      endcase
   endfunction

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            timer_table_apply(cur_req);
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pend_q.size() > 0 &&
                         (!pend_q[0].hold || (exp_q.size() == 0 && !req_valid))) begin
               cur_req = pend_q.pop_front();
               req_valid <= 1'b1;
               req_opcode <= cur_req.op;
               req_thread_id <= cur_req.thread_id;
               req_now_cycles <= cur_req.now;
               req_value_cycles <= cur_req.value;
               req_period_cycles <= cur_req.period;
               if ($urandom_range(0, 39) == 0)
                  send_steady = !send_steady;
               send_gap = send_steady ? 0 : idle_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and checker.
   always @(posedge clock) begin
      timer_word_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_kind == pitt_pkg::KIND_EXPIRY)
               n_expiry_words++;
            if (exp_q.size() == 0) begin
               report_mismatch($sformatf("unexpected word kind %0d owner %h", rsp_kind,
                                         rsp_owner_id));
            end else begin
               want = exp_q.pop_front();
               if (rsp_kind !== want.kind)
                  report_mismatch($sformatf("word %0d kind got %0d want %0d", n_words,
                                            rsp_kind, want.kind));
               if (rsp_owner_id !== want.owner)
                  report_mismatch($sformatf("word %0d owner got %h want %h", n_words,
                                            rsp_owner_id, want.owner));
               if (rsp_remaining_cycles !== want.remaining)
                  report_mismatch($sformatf("word %0d remaining got %h want %h", n_words,
                                            rsp_remaining_cycles, want.remaining));
               if (rsp_reload_cycles !== want.reload)
                  report_mismatch($sformatf("word %0d reload got %h want %h", n_words,
                                            rsp_reload_cycles, want.reload));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("word %0d status got %b want %b", n_words,
                                            rsp_status, want.status));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("word %0d last got %b want %b", n_words,
                                            rsp_last, want.last));
            end
            n_words++;
            if ($urandom_range(0, 39) == 0)
               recv_steady = !recv_steady;
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!recv_steady && $urandom_range(0, 3) == 0)
               recv_gap = idle_len();
         end
      end
   end

   initial begin
      logic [pitt_pkg::TIME_W-1:0]   sim_now;
      logic [pitt_pkg::TIME_W-1:0]   now;
      logic [pitt_pkg::TIME_W-1:0]   value;
      logic [pitt_pkg::TIME_W-1:0]   period;
      logic [pitt_pkg::THREAD_W-1:0] id;
      logic [pitt_pkg::OP_W-1:0]     op;
      int                            r;
      int                            k;

      // Empty table: a read and a cancel of a thread without a timer, then an unused opcode.
      queue_req(pitt_pkg::OP_READ, 16'h0000, 64'd10, '0, '0);
      queue_req(pitt_pkg::OP_SET, 16'h0000, 64'd10, '0, '0);
      queue_req(OP_UNUSED, '1, '1, '1, '1);
      queue_req(pitt_pkg::OP_SET, 16'hFFFF, 64'd100, 64'd50, '0);
      queue_req(pitt_pkg::OP_SET, 16'h0000, 64'd100, 64'd10, 64'd25);
      queue_req(pitt_pkg::OP_READ, 16'hFFFF, 64'd120, '0, '0);
      // The deadline has already passed, so the time left saturates at zero.
      queue_req(pitt_pkg::OP_READ, 16'h0000, 64'd200, '0, '0);
      // One deadline equals now exactly; the one-shot is freed and the periodic one re-armed.
      queue_req(pitt_pkg::OP_CHECK, 16'h1234, 64'd150, '0, '0);
      queue_req(pitt_pkg::OP_SET, 16'h0000, 64'd160, '0, '0);

      // Fill every slot, including a deadline that wraps past 2^64 and all-ones values.
      for (int i = 0; i < pitt_pkg::TIMER_SLOTS; i++) begin
         now = 64'd1000;
         value = 64'(1 + i);
         period = (i % 3 == 0) ? '0 : 64'(10 + i);
         if (i == 3)
            now = '1;
         if (i == 5)
            value = '1;
         if (i == 7)
            period = '1;
         queue_req(pitt_pkg::OP_SET, 16'(i * 16'h1111), now, value, period);
      end
      queue_req(pitt_pkg::OP_SET, 16'h0F0F, 64'd1000, 64'd10, 64'd5);
      queue_req(pitt_pkg::OP_SET, 16'h2222, 64'd1000, 64'd3, '0);
      // Every slot expires at once: sixteen expiry words and the done word.
      queue_req(pitt_pkg::OP_CHECK, '0, 64'd2000, '0, '0);

      for (int i = 0; i < 24; i++)
         id_pool[i] = 16'($urandom);
      id_pool[0] = 16'h0000;
      id_pool[1] = 16'hFFFF;

      sim_now = 64'd2000;
      k = 0;
      while (k < 190) begin
         sim_now += $urandom_range(0, 30);
         // Move the clock close to the top of its range so later deadlines wrap.
         if (k == 120)
            sim_now = 64'hFFFF_FFFF_FFFF_FE00;
         r = $urandom_range(0, 99);
         op = (r < 40) ? pitt_pkg::OP_SET : (r < 65) ? pitt_pkg::OP_READ :
              (r < 95) ? pitt_pkg::OP_CHECK : OP_UNUSED;
         id = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, 23)] : 16'($urandom);
         now = ($urandom_range(0, 99) < 3) ? rand_time() : sim_now;
         r = $urandom_range(0, 99);
         value = (r < 18) ? '0 : (r < 90) ? 64'($urandom_range(1, 150)) :
                 (r < 96) ? 64'($urandom) : rand_time();
         r = $urandom_range(0, 99);
         period = (r < 40) ? '0 : (r < 90) ? 64'($urandom_range(1, 120)) : rand_time();
         queue_req(op, id, now, value, period, (k == 0 || k == 150));
         if (op != OP_UNUSED)
            k++;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pend_q.size() > 0 || req_valid)
         @(posedge clock);
      while (exp_q.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Ran %0d sets (%0d refused on a full table), %0d reads and %0d checks.",
               n_sets, n_full, n_reads, n_checks);
      $display("Checked %0d response words, %0d of them expiries; %0d mismatches.",
               n_words, n_expiry_words, n_errors);
      if (n_errors == 0)
         $display("per_thread_interval_timer_table_tb passed");
      else
         $display("per_thread_interval_timer_table_tb failed");
      $finish;
   end

   initial begin
      #8_000_000;
      $display("Timed out with %0d requests and %0d words still pending.",
               pend_q.size(), exp_q.size());
      $display("per_thread_interval_timer_table_tb failed");
      $finish;
   end

endmodule
